// File: rtl/core/gradient_optimizer_update_unit_assert.svh
// ----------------------------------------------------------------------------
// Gradient optimizer update unit - assertion macros
// Shorthand for the clocked, reset-qualified checks of the update unit.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_OPTIMIZER_UPDATE_UNIT_ASSERT_SVH
`define GRADIENT_OPTIMIZER_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GOU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gradient optimizer update unit check failed");

// Next-cycle implication.
`define GOU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gradient optimizer update unit check failed");

`endif

// File: rtl/core/gou_pkg.sv
// ----------------------------------------------------------------------------
// Gradient optimizer update package
// Widths, codes, shared types and the saturation helper of the update unit.
// ----------------------------------------------------------------------------
package gou_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int IDX_W       = 10;
  localparam int DATA_W      = 32;
  localparam int COEF_W      = 24;
  localparam int EPS_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int MUL_W       = DATA_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int WIDE_W      = PROD_W + 2;
  localparam int NUM_W       = 56;
  localparam int DEN_W       = 32;
  localparam int REM_W       = DEN_W + 2;
  localparam int CNT_W       = 6;
  localparam int DIV_STEPS   = NUM_W;
  localparam int SQRT_STEPS  = 24;

  localparam logic [COEF_W:0] ONE_Q24 = {1'b1, {COEF_W{1'b0}}};

  localparam logic signed [WIDE_W-1:0] DATA_MAX_W =
    {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] DATA_MIN_W =
    {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_DESCENT  = 2'd0,
    MODE_MOMENTUM = 2'd1,
    MODE_RMSPROP  = 2'd2,
    MODE_ADAM     = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_LR      = 3'd1,
    REG_DECAY_A = 3'd2,
    REG_DECAY_B = 3'd3,
    REG_EPSILON = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } iter_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NUM_W-1:0]  quot;
  } iter_stat_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] val;
  } clip_t;

  function automatic clip_t clip_data(input logic signed [WIDE_W-1:0] x);
    clip_t r;
    if (x > DATA_MAX_W) begin
      r.hit = 1'b1;
      r.val = DATA_MAX_W[DATA_W-1:0];
    end else if (x < DATA_MIN_W) begin
      r.hit = 1'b1;
      r.val = DATA_MIN_W[DATA_W-1:0];
    end else begin
      r.hit = 1'b0;
      r.val = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/gou_iter_unit.sv
// ----------------------------------------------------------------------------
// Gradient optimizer iterative divide / square root unit
// Shared compare-subtract recurrence: one quotient bit or one root bit a cycle.
// ----------------------------------------------------------------------------
module gou_iter_unit
  import gou_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  iter_req_t  req_i,
  output iter_stat_t stat_o
);

  logic             busy_q;
  logic             done_q;
  logic             sqrt_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    if (sqrt_q) begin
      rem_shift = {rem_q[REM_W-3:0], num_q[NUM_W-1 -: 2]};
      trial     = {quo_q[REM_W-3:0], 2'b01};
    end else begin
      rem_shift = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
      trial     = {2'b00, den_q};
    end
    ge = rem_shift >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.is_sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_shift - trial : rem_shift;
      quo_q <= {quo_q[NUM_W-2:0], ge};
      num_q <= sqrt_q ? {num_q[NUM_W-3:0], 2'b00} : {num_q[NUM_W-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.quot = quo_q;

endmodule

// File: rtl/core/gradient_optimizer_update_unit.sv
// ----------------------------------------------------------------------------
// Gradient optimizer update unit
// Parameter table with descent, momentum, RMSProp and Adam update rules.
//
//   Channel  Dir  Payload
//   s_axis   in   tuser: op; tdata: entry_index, gradient, write_value
//   m_axis   out  tuser: saturated; tdata: result_index, result_value
//   cfg      in   cfg_we_i, cfg_index_i, cfg_data_i
//
// Items are, from shortest to longest: read, write, descent, momentum,
// RMSProp and Adam.
// The long rules are set by the shared divide / square root unit: 56 steps a
// division and 24 a root. After reset a clearing pass zeroes all 1024
// entries of the table; no input transfer is taken meanwhile. A finished
// result waits in the output register while the next item is accepted; the
// item after that waits in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
`include "gradient_optimizer_update_unit_assert.svh"

module gradient_optimizer_update_unit
  import gou_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [79:0]          s_axis_tdata,   // entry_index, gradient, write_value
  input  logic [1:0]           s_axis_tuser,   // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // result_index, result_value
  output logic                 m_axis_tuser,   // saturated
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD,
    ST_D0_MUL, ST_D0_FIN,
    ST_M1_MUL, ST_M1_MOM, ST_M1_MUL2, ST_M1_FIN,
    ST_SQ_MUL, ST_SQ_FIN,
    ST_R_MUL1, ST_R_MUL2, ST_R_S,
    ST_A_MUL1, ST_A_MUL2, ST_A_M, ST_A_MUL3, ST_A_S,
    ST_MH_GO, ST_MH_WAIT, ST_SH_GO, ST_SH_WAIT,
    ST_ROOT_GO, ST_ROOT_WAIT, ST_NUM_MUL, ST_NUM, ST_DIV_WAIT,
    ST_WB, ST_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] s;
  } entry_t;

  state_e state_q;

  mode_e             mode_q;
  logic [COEF_W-1:0] lr_q;
  logic [COEF_W-1:0] dec_a_q;
  logic [COEF_W-1:0] dec_b_q;
  logic [EPS_W-1:0]  eps_q;

  entry_t            mem_q [NUM_ENTRIES];
  entry_t            rdata_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  entry_t            mem_wdata;

  op_e                       op_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [DATA_W-1:0]  g_q;
  logic signed [DATA_W-1:0]  wv_q;
  logic signed [DATA_W-1:0]  v_q;
  logic signed [DATA_W-1:0]  m_q;
  logic signed [DATA_W-1:0]  s_q;
  logic signed [DATA_W-1:0]  q_q;
  logic signed [DATA_W-1:0]  mh_q;
  logic signed [DATA_W-1:0]  sh_q;
  logic signed [WIDE_W-1:0]  acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [DEN_W-1:0]          den_q;
  logic                      div_neg_q;
  logic                      sat_q;

  logic                      out_valid_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic [DATA_W-1:0]         out_val_q;
  logic                      out_sat_q;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic [COEF_W:0]           one_minus_a;
  logic [COEF_W:0]           one_minus_b;

  iter_req_t                 it_req;
  iter_stat_t                it_stat;

  logic signed [WIDE_W-1:0]  p_w;
  logic signed [WIDE_W-1:0]  v_w;
  logic signed [WIDE_W-1:0]  g_w;
  logic signed [WIDE_W-1:0]  sum_sh;
  logic signed [WIDE_W-1:0]  quot_w;
  logic signed [WIDE_W-1:0]  qs_w;
  logic signed [WIDE_W-1:0]  p_abs;
  logic signed [DATA_W:0]    m_abs;
  logic [COEF_W:0]           root_eps;
  clip_t                     d0_c, m1_m_c, m1_v_c, acc_c, mh_c, sh_c, vdiv_c;

  logic in_xfer;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign one_minus_a = ONE_Q24 - {1'b0, dec_a_q};
  assign one_minus_b = ONE_Q24 - {1'b0, dec_b_q};

  assign p_w    = WIDE_W'(prod_q);
  assign v_w    = WIDE_W'(v_q);
  assign g_w    = WIDE_W'(g_q);
  assign sum_sh = (acc_q + p_w) >>> COEF_W;
  assign quot_w = signed'(WIDE_W'(it_stat.quot));
  assign qs_w   = div_neg_q ? -quot_w : quot_w;
  assign p_abs  = prod_q[PROD_W-1] ? -p_w : p_w;
  assign m_abs  = m_q[DATA_W-1] ? -(DATA_W+1)'(m_q) : (DATA_W+1)'(m_q);
  assign root_eps = {1'b0, it_stat.quot[COEF_W-1:0]} + {{(COEF_W-EPS_W+1){1'b0}}, eps_q};

  assign d0_c   = clip_data(v_w - (p_w >>> COEF_W));
  assign m1_m_c = clip_data((p_w >>> COEF_W) - g_w);
  assign m1_v_c = clip_data(v_w + (p_w >>> COEF_W));
  assign acc_c  = clip_data(sum_sh);
  assign mh_c   = clip_data(qs_w);
  assign sh_c   = clip_data(quot_w);
  assign vdiv_c = clip_data(v_w - qs_w);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_D0_MUL: begin
        mul_a = MUL_W'(g_q);
        mul_b = signed'(MUL_W'(lr_q));
      end
      ST_M1_MUL, ST_A_MUL1: begin
        mul_a = signed'(MUL_W'(dec_a_q));
        mul_b = MUL_W'(m_q);
      end
      ST_M1_MUL2: begin
        mul_a = MUL_W'(m_q);
        mul_b = signed'(MUL_W'(lr_q));
      end
      ST_SQ_MUL: begin
        mul_a = MUL_W'(g_q);
        mul_b = MUL_W'(g_q);
      end
      ST_R_MUL1: begin
        mul_a = signed'(MUL_W'(dec_a_q));
        mul_b = MUL_W'(s_q);
      end
      ST_R_MUL2: begin
        mul_a = signed'(MUL_W'(one_minus_a));
        mul_b = MUL_W'(q_q);
      end
      ST_A_MUL2: begin
        mul_a = signed'(MUL_W'(one_minus_a));
        mul_b = MUL_W'(g_q);
      end
      ST_A_M: begin
        mul_a = signed'(MUL_W'(dec_b_q));
        mul_b = MUL_W'(s_q);
      end
      ST_A_MUL3: begin
        mul_a = signed'(MUL_W'(one_minus_b));
        mul_b = MUL_W'(q_q);
      end
      ST_NUM_MUL: begin
        mul_a = signed'(MUL_W'(lr_q));
        mul_b = (mode_q == MODE_RMSPROP) ? MUL_W'(g_q) : MUL_W'(mh_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    it_req = '0;
    case (state_q)
      ST_MH_GO: begin
        it_req.start = 1'b1;
        it_req.num   = {m_abs[NUM_W-COEF_W-1:0], {COEF_W{1'b0}}};
        it_req.den   = DEN_W'(one_minus_a);
      end
      ST_SH_GO: begin
        it_req.start = 1'b1;
        it_req.num   = {s_q[NUM_W-COEF_W-1:0], {COEF_W{1'b0}}};
        it_req.den   = DEN_W'(one_minus_b);
      end
      ST_ROOT_GO: begin
        it_req.start   = 1'b1;
        it_req.is_sqrt = 1'b1;
        it_req.num     = (mode_q == MODE_RMSPROP) ?
                         {1'b0, s_q[DATA_W-2:0], 24'd0} : {1'b0, sh_q[DATA_W-2:0], 24'd0};
      end
      ST_NUM: begin
        it_req.start = 1'b1;
        it_req.num   = p_abs[NUM_W-1:0];
        it_req.den   = den_q;
      end
      default: it_req = '0;
    endcase
  end

  gou_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .stat_o (it_stat)
  );

  assign mem_addr  = (state_q == ST_CLEAR) ? clr_cnt_q : idx_q[ADDR_W-1:0];
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WB);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {v_q, m_q, s_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_DESCENT;
      lr_q    <= COEF_W'(16777);
      dec_a_q <= COEF_W'(15099494);
      dec_b_q <= COEF_W'(16760439);
      eps_q   <= EPS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODE:    mode_q  <= mode_e'(cfg_data_i[1:0]);
        REG_LR:      lr_q    <= cfg_data_i;
        REG_DECAY_A: dec_a_q <= cfg_data_i;
        REG_DECAY_B: dec_b_q <= cfg_data_i;
        REG_EPSILON: eps_q   <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= idx_q;
        out_val_q   <= v_q;
        out_sat_q   <= sat_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(NUM_ENTRIES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            op_q    <= op_e'(s_axis_tuser);
            idx_q   <= s_axis_tdata[IDX_W-1:0];
            g_q     <= s_axis_tdata[IDX_W +: DATA_W];
            wv_q    <= s_axis_tdata[IDX_W+DATA_W +: DATA_W];
            sat_q   <= 1'b0;
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_LOAD;
        ST_LOAD: begin
          m_q <= rdata_q.m;
          s_q <= rdata_q.s;
          case (op_q)
            OP_WRITE: begin
              v_q     <= wv_q;
              state_q <= ST_WB;
            end
            OP_UPDATE: begin
              v_q <= rdata_q.v;
              case (mode_q)
                MODE_DESCENT:  state_q <= ST_D0_MUL;
                MODE_MOMENTUM: state_q <= ST_M1_MUL;
                default:       state_q <= ST_SQ_MUL;
              endcase
            end
            default: begin
              v_q     <= rdata_q.v;
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_D0_MUL: state_q <= ST_D0_FIN;
        ST_D0_FIN: begin
          v_q     <= d0_c.val;
          sat_q   <= sat_q | d0_c.hit;
          state_q <= ST_WB;
        end
        ST_M1_MUL: state_q <= ST_M1_MOM;
        ST_M1_MOM: begin
          m_q     <= m1_m_c.val;
          sat_q   <= sat_q | m1_m_c.hit;
          state_q <= ST_M1_MUL2;
        end
        ST_M1_MUL2: state_q <= ST_M1_FIN;
        ST_M1_FIN: begin
          v_q     <= m1_v_c.val;
          sat_q   <= sat_q | m1_v_c.hit;
          state_q <= ST_WB;
        end
        ST_SQ_MUL: state_q <= ST_SQ_FIN;
        ST_SQ_FIN: begin
          q_q     <= ((p_w >>> 16) > DATA_MAX_W) ? DATA_MAX_W[DATA_W-1:0]
                                                 : p_w[16 +: DATA_W];
          state_q <= (mode_q == MODE_RMSPROP) ? ST_R_MUL1 : ST_A_MUL1;
        end
        ST_R_MUL1: state_q <= ST_R_MUL2;
        ST_R_MUL2: begin
          acc_q   <= p_w;
          state_q <= ST_R_S;
        end
        ST_R_S: begin
          s_q     <= acc_c.val;
          sat_q   <= sat_q | acc_c.hit;
          state_q <= ST_ROOT_GO;
        end
        ST_A_MUL1: state_q <= ST_A_MUL2;
        ST_A_MUL2: begin
          acc_q   <= p_w;
          state_q <= ST_A_M;
        end
        ST_A_M: begin
          m_q     <= acc_c.val;
          sat_q   <= sat_q | acc_c.hit;
          state_q <= ST_A_MUL3;
        end
        ST_A_MUL3: begin
          acc_q   <= p_w;
          state_q <= ST_A_S;
        end
        ST_A_S: begin
          s_q     <= acc_c.val;
          sat_q   <= sat_q | acc_c.hit;
          state_q <= ST_MH_GO;
        end
        ST_MH_GO: begin
          div_neg_q <= m_q[DATA_W-1];
          state_q   <= ST_MH_WAIT;
        end
        ST_MH_WAIT: begin
          if (it_stat.done) begin
            mh_q    <= mh_c.val;
            state_q <= ST_SH_GO;
          end
        end
        ST_SH_GO: state_q <= ST_SH_WAIT;
        ST_SH_WAIT: begin
          if (it_stat.done) begin
            sh_q    <= sh_c.val;
            state_q <= ST_ROOT_GO;
          end
        end
        ST_ROOT_GO: state_q <= ST_ROOT_WAIT;
        ST_ROOT_WAIT: begin
          if (it_stat.done) begin
            den_q   <= (root_eps == '0) ? DEN_W'(256)
                                        : {root_eps[COEF_W-1:0], 8'd0};
            state_q <= ST_NUM_MUL;
          end
        end
        ST_NUM_MUL: state_q <= ST_NUM;
        ST_NUM: begin
          div_neg_q <= prod_q[PROD_W-1];
          state_q   <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (it_stat.done) begin
            v_q     <= vdiv_c.val;
            sat_q   <= sat_q | vdiv_c.hit;
            state_q <= ST_WB;
          end
        end
        ST_WB: state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_val_q, out_idx_q};
  assign m_axis_tuser  = out_sat_q;

  `GOU_ASSERT_SAME(a_no_input_in_clear, state_q == ST_CLEAR, !s_axis_tready)
  `GOU_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_axis_tready)
  `GOU_ASSERT_SAME(a_table_write_window, mem_we, state_q == ST_CLEAR || state_q == ST_WB)
  `GOU_ASSERT_SAME(a_unit_free_on_start, it_req.start, !it_stat.busy)

endmodule
